>>> hdl/lcdst_pkg.sv
`default_nettype none

package lcdst_pkg;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_RD_STATUS = 2'd1,
        REQ_WR_ENABLE = 2'd2,
        REQ_RD_LINE   = 2'd3
    } req_type_t;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT_COMPARE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_BLANK    = 1'd1;

    localparam int EN_VBLANK_BIT = 3;
    localparam int EN_HBLANK_BIT = 4;
    localparam int EN_VCOUNT_BIT = 5;

    typedef struct packed {
        req_type_t   req_type;
        logic [9:0]  tick_count;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_vblank;
        logic        irq_hblank;
        logic        irq_vcount;
        logic        dma_hblank;
        logic        dma_vblank;
        logic        frame_start;
        logic        vblank_event;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/lcd_scanline_timing_status.sv
// An input transfer is captured in the stage register; its result is then registered into the output register.
// Throughput: one item per cycle while the output is not stalled; the timing update is one add, saturate and compare.
// in_stall follows out_stall combinationally only while both stages are full.
// Reset (rst_n low, asynchronous): line 227 awaiting line end with the accumulator
// at LINE_TICKS, all flags, enables and config registers cleared, both stages empty.
`default_nettype none

module lcd_scanline_timing_status #(
    parameter int LINE_TICKS    = 1232,
    parameter int HDRAW_TICKS   = 960,
    parameter int TOTAL_LINES   = 228,
    parameter int VISIBLE_LINES = 160
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire lcdst_pkg::in_item_t             in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output lcdst_pkg::out_item_t                 out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lcdst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcdst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lcdst_pkg::*;

    localparam int ACCUM_MAX = (2 * LINE_TICKS - 1) > 2047 ? (2 * LINE_TICKS - 1) : 2047;
    localparam int ACC_W     = $clog2(ACCUM_MAX + 1);
    localparam int LINE_W    = $clog2(TOTAL_LINES);

    localparam logic [ACC_W-1:0]  ACC_SAT   = ACC_W'(ACCUM_MAX);
    localparam logic [ACC_W-1:0]  ACC_LINE  = ACC_W'(LINE_TICKS);
    localparam logic [ACC_W-1:0]  ACC_HDRAW = ACC_W'(HDRAW_TICKS);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(TOTAL_LINES - 1);
    localparam logic [7:0]        VIS_LINES = 8'(VISIBLE_LINES);

    logic [7:0]        vcount_compare_reg;
    logic              force_blank_reg;

    logic              stage_valid_reg, stage_valid_next;
    in_item_t          stage_data_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [ACC_W-1:0]  accum_reg, accum_next;
    logic              await_end_reg, await_end_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              vblank_reg, vblank_next;
    logic              hblank_reg, hblank_next;
    logic              vmatch_reg, vmatch_next;
    logic [2:0]        irq_en_reg, irq_en_next;

    logic              in_xfer;
    logic              advance;
    logic              process;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  sat;
    logic [LINE_W-1:0] line_inc;
    logic [7:0]        line_ext;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = stage_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign process   = stage_valid_reg && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sum      = {1'b0, accum_reg} + (ACC_W + 1)'(stage_data_reg.tick_count);
    assign sat      = (sum > {1'b0, ACC_SAT}) ? ACC_SAT : sum[ACC_W-1:0];
    assign line_inc = (line_reg == LAST_LINE) ? '0 : line_reg + 1'b1;
    assign line_ext = 8'(line_inc);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_xfer)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = advance ? stage_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        accum_next     = accum_reg;
        await_end_next = await_end_reg;
        line_next      = line_reg;
        vblank_next    = vblank_reg;
        hblank_next    = hblank_reg;
        vmatch_next    = vmatch_reg;
        irq_en_next    = irq_en_reg;
        out_data_next  = '0;

        unique case (stage_data_reg.req_type)
            REQ_TICK:
            begin
                accum_next = sat;
                if (await_end_reg)
                begin
                    if (sat >= ACC_LINE)
                    begin
                        accum_next     = sat - ACC_LINE;
                        await_end_next = 1'b0;
                        line_next      = line_inc;
                        hblank_next    = 1'b0;
                        vmatch_next    = (line_ext == vcount_compare_reg);
                        out_data_next.irq_vcount = (line_ext == vcount_compare_reg)
                                                   && irq_en_reg[2];
                        if (line_ext == 8'd0)
                        begin
                            vblank_next               = 1'b0;
                            out_data_next.frame_start = 1'b1;
                        end
                        else if (line_ext == VIS_LINES)
                        begin
                            vblank_next                = 1'b1;
                            out_data_next.vblank_event = 1'b1;
                            out_data_next.dma_vblank   = 1'b1;
                            out_data_next.irq_vblank   = irq_en_reg[0];
                        end
                    end
                end
                else if (sat >= ACC_HDRAW)
                begin
                    await_end_next           = 1'b1;
                    hblank_next              = 1'b1;
                    out_data_next.irq_hblank = irq_en_reg[1];
                    out_data_next.dma_hblank = (8'(line_reg) < VIS_LINES) && !force_blank_reg;
                end
            end
            REQ_RD_STATUS:
                out_data_next.read_data = {2'b00, irq_en_reg, vmatch_reg, hblank_reg,
                                           vblank_reg};
            REQ_WR_ENABLE:
                irq_en_next = {stage_data_reg.write_data[EN_VCOUNT_BIT],
                               stage_data_reg.write_data[EN_HBLANK_BIT],
                               stage_data_reg.write_data[EN_VBLANK_BIT]};
            REQ_RD_LINE:
                out_data_next.read_data = 8'(line_reg);
            default:
                out_data_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
            vcount_compare_reg <= '0;
            force_blank_reg    <= 1'b0;
            accum_reg          <= ACC_LINE;
            await_end_reg      <= 1'b1;
            line_reg           <= LAST_LINE;
            vblank_reg         <= 1'b0;
            hblank_reg         <= 1'b0;
            vmatch_reg         <= 1'b0;
            irq_en_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_VCOUNT_COMPARE: vcount_compare_reg <= cfg_data;
                    CFG_FORCE_BLANK:    force_blank_reg    <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (process)
            begin
                accum_reg     <= accum_next;
                await_end_reg <= await_end_next;
                line_reg      <= line_next;
                vblank_reg    <= vblank_next;
                hblank_reg    <= hblank_next;
                vmatch_reg    <= vmatch_next;
                irq_en_reg    <= irq_en_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            stage_data_reg <= in_data;
        if (process)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> hdl/lcdst_checker.sv
`default_nettype none

module lcdst_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire lcdst_pkg::out_item_t out_data
);
    import lcdst_pkg::*;

    logic any_pulse;

    assign any_pulse = out_data.irq_vblank || out_data.irq_hblank || out_data.irq_vcount
                       || out_data.dma_hblank || out_data.dma_vblank
                       || out_data.frame_start || out_data.vblank_event;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted item did not reach the output in two cycles");

    a_read_vs_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && any_pulse |-> out_data.read_data == 8'd0)
        else $error("timing pulse on a read or write result");

    a_vblank_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.irq_vblank || out_data.dma_vblank)
        |-> out_data.vblank_event && !out_data.frame_start && !out_data.irq_hblank)
        else $error("vblank pulses inconsistent");

endmodule

bind lcd_scanline_timing_status lcdst_checker u_lcdst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lcdst_pkg::*;

    localparam int unsigned LINE_TICKS    = 1232;
    localparam int unsigned HDRAW_TICKS   = 960;
    localparam int unsigned TOTAL_LINES   = 228;
    localparam int unsigned VISIBLE_LINES = 160;
    localparam int unsigned ACCUM_MAX     = (2 * LINE_TICKS - 1 > 2047) ?
                                            (2 * LINE_TICKS - 1) : 2047;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lcd_scanline_timing_status dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted display state
    int unsigned tick_acc = LINE_TICKS;
    bit          wait_line_end = 1'b1;
    int unsigned cur_line = TOTAL_LINES - 1;
    bit          vblank_flag = 1'b0;
    bit          hblank_flag = 1'b0;
    bit          match_flag = 1'b0;
    logic [2:0]  irq_en = '0;
    logic [7:0]  line_cmp = '0;
    bit          blank_force = 1'b0;

    in_item_t    tx_items[$];
    out_item_t   scanline_results[$];
    int unsigned items_sent = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    bit          hold_off = 1'b0;

    int unsigned tx_gap = 0;
    int unsigned tx_quiet = 0;
    int unsigned rx_left = 0;
    int unsigned rx_quiet = 0;
    logic        tx_valid_nxt;
    in_item_t    tx_data_nxt;
    logic        rx_stall_nxt;
    out_item_t   due;

    function automatic out_item_t scanline_step(in_item_t it);
        out_item_t   r;
        int unsigned sum;
        r = '0;
        case (it.req_type)
            REQ_TICK:
            begin
                sum = tick_acc + it.tick_count;
                tick_acc = (sum > ACCUM_MAX) ? ACCUM_MAX : sum;
                if (wait_line_end)
                begin
                    if (tick_acc >= LINE_TICKS)
                    begin
                        tick_acc = tick_acc - LINE_TICKS;
                        wait_line_end = 1'b0;
                        cur_line = (cur_line + 1) % TOTAL_LINES;
                        hblank_flag = 1'b0;
                        match_flag = (cur_line == line_cmp);
                        r.irq_vcount = match_flag & irq_en[2];
                        if (cur_line == 0)
                        begin
                            vblank_flag = 1'b0;
                            r.frame_start = 1'b1;
                        end
                        else if (cur_line == VISIBLE_LINES)
                        begin
                            vblank_flag = 1'b1;
                            r.vblank_event = 1'b1;
                            r.dma_vblank = 1'b1;
                            r.irq_vblank = irq_en[0];
                        end
                    end
                end
                else if (tick_acc >= HDRAW_TICKS)
                begin
                    wait_line_end = 1'b1;
                    hblank_flag = 1'b1;
                    r.irq_hblank = irq_en[1];
                    r.dma_hblank = (cur_line < VISIBLE_LINES) && !blank_force;
                end
            end
            REQ_RD_STATUS:
                r.read_data = {2'b00, irq_en, match_flag, hblank_flag, vblank_flag};
            REQ_WR_ENABLE:
                irq_en = {it.write_data[EN_VCOUNT_BIT], it.write_data[EN_HBLANK_BIT],
                          it.write_data[EN_VBLANK_BIT]};
            default:
                r.read_data = cur_line[7:0];
        endcase
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        else if (k < 85)
            return $urandom_range(1, 3);
        else if (k < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned k;
        it.tick_count = 10'($urandom_range(0, 1023));
        it.write_data = 8'($urandom_range(0, 255));
        k = $urandom_range(0, 99);
        if (k < 74)
        begin
            it.req_type = REQ_TICK;
            case ($urandom_range(0, 9))
                0:       it.tick_count = 10'd0;
                1:       it.tick_count = 10'd1023;
                2, 3:    it.tick_count = 10'($urandom_range(0, 1023));
                default: it.tick_count = 10'($urandom_range(500, 1023));
            endcase
        end
        else if (k < 84)
            it.req_type = REQ_RD_STATUS;
        else if (k < 92)
            it.req_type = REQ_RD_LINE;
        else
            it.req_type = REQ_WR_ENABLE;
        return it;
    endfunction

    task automatic queue_item(input req_type_t rt, input logic [9:0] ticks,
                              input logic [7:0] wdata);
        in_item_t it;
        it.req_type = rt;
        it.tick_count = ticks;
        it.write_data = wdata;
        tx_items.push_back(it);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_VCOUNT_COMPARE)
            line_cmp = val;
        else
            blank_force = val[0];
    endtask

    task automatic drain();
        while (results_seen != items_sent)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            tx_valid_nxt = in_valid;
            tx_data_nxt = in_data;
            if (in_valid && !in_stall)
            begin
                scanline_results.push_back(scanline_step(in_data));
                items_taken++;
                tx_valid_nxt = 1'b0;
            end
            if (!tx_valid_nxt)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (tx_items.size() > 0)
                begin
                    tx_data_nxt = tx_items.pop_front();
                    tx_valid_nxt = 1'b1;
                    if (tx_quiet > 0)
                    begin
                        tx_quiet--;
                        tx_gap = 0;
                    end
                    else
                    begin
                        tx_gap = gap_len();
                        if ($urandom_range(0, 49) == 0)
                            tx_quiet = $urandom_range(20, 80);
                    end
                end
            end
            in_valid <= tx_valid_nxt;
            in_data <= tx_data_nxt;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (scanline_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: rd=%02h flags=%b", out_data.read_data,
                                 out_data[6:0]);
                end
                else
                begin
                    due = scanline_results.pop_front();
                    if (out_data.read_data !== due.read_data ||
                        out_data.irq_vblank !== due.irq_vblank ||
                        out_data.irq_hblank !== due.irq_hblank ||
                        out_data.irq_vcount !== due.irq_vcount ||
                        out_data.dma_hblank !== due.dma_hblank ||
                        out_data.dma_vblank !== due.dma_vblank ||
                        out_data.frame_start !== due.frame_start ||
                        out_data.vblank_event !== due.vblank_event)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch #%0d: rd exp %02h got %02h, %s exp %b got %b",
                                     results_seen, due.read_data, out_data.read_data,
                                     "ivb/ihb/ivc/dhb/dvb/fs/ve", due[6:0], out_data[6:0]);
                    end
                end
            end
            if (rx_left > 0)
            begin
                rx_left--;
                rx_stall_nxt = 1'b1;
            end
            else
            begin
                rx_stall_nxt = 1'b0;
                if (rx_quiet > 0)
                    rx_quiet--;
                else if ($urandom_range(0, 59) == 0)
                    rx_quiet = $urandom_range(20, 80);
                else if ($urandom_range(0, 3) == 0)
                    rx_left = gap_len();
            end
            out_stall <= hold_off || rx_stall_nxt;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        while (items_taken < 120)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(REQ_RD_STATUS, 10'd0, 8'h00);
        queue_item(REQ_RD_LINE, 10'd1023, 8'hff);
        queue_item(REQ_WR_ENABLE, 10'd0, 8'hff);
        queue_item(REQ_RD_STATUS, 10'd0, 8'h00);
        queue_item(REQ_TICK, 10'd0, 8'h00);
        queue_item(REQ_TICK, 10'd1023, 8'h00);
        queue_item(REQ_TICK, 10'd1023, 8'hff);
        queue_item(REQ_TICK, 10'd1023, 8'h00);
        queue_item(REQ_TICK, 10'd1023, 8'h00);
        queue_item(REQ_TICK, 10'd0, 8'h00);
        queue_item(REQ_RD_STATUS, 10'd0, 8'h00);
        queue_item(REQ_WR_ENABLE, 10'd0, 8'hc7);
        queue_item(REQ_RD_STATUS, 10'd0, 8'h00);
        queue_item(REQ_TICK, 10'd1, 8'h00);
        queue_item(REQ_TICK, 10'd1023, 8'h00);
        queue_item(REQ_WR_ENABLE, 10'd0, 8'h08);
        queue_item(REQ_TICK, 10'd1023, 8'h00);
        queue_item(REQ_WR_ENABLE, 10'd0, 8'h10);
        queue_item(REQ_TICK, 10'd700, 8'h00);
        queue_item(REQ_WR_ENABLE, 10'd0, 8'h20);
        queue_item(REQ_TICK, 10'd1023, 8'h00);
        queue_item(REQ_RD_LINE, 10'd0, 8'h00);
        queue_item(REQ_WR_ENABLE, 10'd0, 8'h38);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_VCOUNT_COMPARE, 8'd160);
                    write_reg(CFG_FORCE_BLANK, 8'd1);
                end
                1:
                begin
                    write_reg(CFG_VCOUNT_COMPARE, 8'd255);
                    write_reg(CFG_FORCE_BLANK, 8'd0);
                end
                2:
                begin
                    write_reg(CFG_VCOUNT_COMPARE, 8'd0);
                    write_reg(CFG_FORCE_BLANK, 8'd1);
                end
                3:
                begin
                    write_reg(CFG_VCOUNT_COMPARE, 8'($urandom_range(0, TOTAL_LINES - 1)));
                    write_reg(CFG_FORCE_BLANK, 8'd0);
                end
                default:
                begin
                    write_reg(CFG_VCOUNT_COMPARE, 8'(TOTAL_LINES - 1));
                    write_reg(CFG_FORCE_BLANK, 8'($urandom_range(0, 255)));
                end
            endcase
            repeat (160)
            begin
                tx_items.push_back(rand_item());
                items_sent++;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && scanline_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hdl/lcdst_pkg.sv
hdl/lcd_scanline_timing_status.sv
hdl/lcdst_checker.sv
bench/testbench.sv
